// ===== hdl/ctf_pkg.sv =====
package ctf_pkg;

    localparam int CHUNK_MAX = 32;
    localparam int IDX_W = $clog2(CHUNK_MAX);
    localparam int CNT_W = 6;
    localparam int CFG_W = 6;

    localparam logic [CFG_W-1:0] CHUNK_SIZE_RST = 6'd10;

    localparam logic [7:0] ASCII_CR = 8'h0D;
    localparam logic [7:0] ASCII_LF = 8'h0A;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       message_done;
    } t_out_word;

    typedef enum logic [2:0] {
        SEL_HEX_HI,
        SEL_HEX_LO,
        SEL_CR,
        SEL_LF,
        SEL_DATA,
        SEL_ZERO
    } t_byte_sel;

    typedef struct packed {
        logic      load;
        t_byte_sel sel;
        logic      last;
        logic      done;
        logic      store;
        logic      clear_idx;
        logic      advance;
        logic      clear_fill;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
        logic fill_nonzero;
        logic will_emit;
        logic len_ge16;
        logic data_last;
    } t_dp_status;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = ASCII_ZERO + {4'd0, v};
        end else begin
            r = ASCII_UPPER_A + {4'd0, v - 4'd10};
        end
        return r;
    endfunction

endpackage

// ===== hdl/ctf_ctrl.sv =====
module ctf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_mode,
    output logic                o_in_ready,
    input  ctf_pkg::t_dp_status i_status,
    output ctf_pkg::t_ctrl_cmd  o_cmd
);
    import ctf_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_HEXH  = 13'b0000000000010,
        S_HEXL  = 13'b0000000000100,
        S_CR1   = 13'b0000000001000,
        S_LF1   = 13'b0000000010000,
        S_DATA  = 13'b0000000100000,
        S_CR2   = 13'b0000001000000,
        S_LF2   = 13'b0000010000000,
        S_T0    = 13'b0000100000000,
        S_TCR1  = 13'b0001000000000,
        S_TLF1  = 13'b0010000000000,
        S_TCR2  = 13'b0100000000000,
        S_TLF2  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_term, n_term;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_term = r_term;
        o_cmd = '0;
        o_cmd.sel = SEL_CR;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.clear_idx = 1'b1;
                    if (!i_in_mode) begin
                        o_cmd.store = 1'b1;
                        n_term = 1'b0;
                        if (i_status.will_emit) begin
                            n_state = S_HEXH;
                        end
                    end else begin
                        n_term = 1'b1;
                        n_state = i_status.fill_nonzero ? S_HEXH : S_T0;
                    end
                end
            end
            S_HEXH: begin
                o_cmd.sel = SEL_HEX_HI;
                if (!i_status.len_ge16) begin
                    n_state = S_HEXL;
                end else if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state = S_HEXL;
                end
            end
            S_HEXL: begin
                o_cmd.sel = SEL_HEX_LO;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state = S_CR1;
                end
            end
            S_CR1: begin
                o_cmd.sel = SEL_CR;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state = S_LF1;
                end
            end
            S_LF1: begin
                o_cmd.sel = SEL_LF;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                o_cmd.sel = SEL_DATA;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.advance = 1'b1;
                    if (i_status.data_last) begin
                        n_state = S_CR2;
                    end
                end
            end
            S_CR2: begin
                o_cmd.sel = SEL_CR;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state = S_LF2;
                end
            end
            S_LF2: begin
                o_cmd.sel = SEL_LF;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.last = !r_term;
                    o_cmd.clear_fill = 1'b1;
                    n_state = r_term ? S_T0 : S_IDLE;
                end
            end
            S_T0: begin
                o_cmd.sel = SEL_ZERO;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state = S_TCR1;
                end
            end
            S_TCR1: begin
                o_cmd.sel = SEL_CR;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state = S_TLF1;
                end
            end
            S_TLF1: begin
                o_cmd.sel = SEL_LF;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state = S_TCR2;
                end
            end
            S_TCR2: begin
                o_cmd.sel = SEL_CR;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state = S_TLF2;
                end
            end
            S_TLF2: begin
                o_cmd.sel = SEL_LF;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.last = 1'b1;
                    o_cmd.done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_term <= 1'b0;
        end else begin
            r_state <= n_state;
            r_term <= n_term;
        end
    end

`ifndef SYNTHESIS
    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_status.out_free)
        else $error("output word loaded while the output register is occupied");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.done |-> (o_cmd.last && o_cmd.load))
        else $error("message end flagged without end of run");

    a_store_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.store |-> (r_state == S_IDLE && i_in_valid))
        else $error("buffer written outside an accepted word");

    a_emit_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_mode) |=> (r_state == S_HEXH || r_state == S_T0))
        else $error("end of body did not start an emission");
`endif

endmodule

// ===== hdl/ctf_datapath.sv =====
module ctf_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [ctf_pkg::CFG_W-1:0]   i_cfg_data,
    input  ctf_pkg::t_in_word           i_in_data,
    input  ctf_pkg::t_ctrl_cmd          i_cmd,
    output ctf_pkg::t_dp_status         o_status,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output ctf_pkg::t_out_word          o_out_data
);
    import ctf_pkg::*;

    logic [7:0]       r_mem [CHUNK_MAX];
    logic [7:0]       r_rd_data;
    logic [CFG_W-1:0] r_size;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_out_valid;
    t_out_word        r_out;
    logic [CNT_W-1:0] eff_size;
    logic [CNT_W-1:0] fill_inc;
    logic             has_room;
    logic [7:0]       sel_byte;

    assign has_room = (r_fill < CNT_W'(CHUNK_MAX));
    assign fill_inc = has_room ? r_fill + CNT_W'(1) : r_fill;

    always_comb begin
        if (r_size == '0) begin
            eff_size = CNT_W'(1);
        end else if (r_size > CFG_W'(CHUNK_MAX)) begin
            eff_size = CNT_W'(CHUNK_MAX);
        end else begin
            eff_size = CNT_W'(r_size);
        end
    end

    always_comb begin
        if (i_cmd.clear_idx) begin
            n_idx = '0;
        end else if (i_cmd.advance) begin
            n_idx = r_idx + IDX_W'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    always_comb begin
        if (i_cmd.clear_fill) begin
            n_fill = '0;
        end else if (i_cmd.store) begin
            n_fill = fill_inc;
        end else begin
            n_fill = r_fill;
        end
    end

    always_comb begin
        case (i_cmd.sel)
            SEL_HEX_HI: sel_byte = hex_digit(4'(r_fill >> 4));
            SEL_HEX_LO: sel_byte = hex_digit(r_fill[3:0]);
            SEL_CR:     sel_byte = ASCII_CR;
            SEL_LF:     sel_byte = ASCII_LF;
            SEL_DATA:   sel_byte = r_rd_data;
            SEL_ZERO:   sel_byte = ASCII_ZERO;
            default:    sel_byte = ASCII_CR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && has_room) begin
            r_mem[r_fill[IDX_W-1:0]] <= i_in_data.data_byte;
        end
        r_rd_data <= r_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= CHUNK_SIZE_RST;
            r_fill <= '0;
            r_idx <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_size <= i_cfg_data;
            end
            r_fill <= n_fill;
            r_idx <= n_idx;
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.out_byte <= sel_byte;
            r_out.last_of_run <= i_cmd.last;
            r_out.message_done <= i_cmd.done;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.fill_nonzero = (r_fill != '0);
    assign o_status.will_emit = (fill_inc >= eff_size);
    assign o_status.len_ge16 = (r_fill >= CNT_W'(16));
    assign o_status.data_last = ({1'b0, r_idx} == (r_fill - CNT_W'(1)));

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

`ifndef SYNTHESIS
    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(CHUNK_MAX))
        else $error("fill count beyond buffer depth");

    a_fill_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_fill |=> (r_fill == '0))
        else $error("fill count not cleared after chunk");

    a_data_word_in_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && i_cmd.sel == SEL_DATA) |-> (r_fill != '0))
        else $error("data word sent from an empty buffer");
`endif

endmodule

// ===== hdl/chunked_transfer_framer_core.sv =====
// A word that completes a chunk moves the control from S_IDLE to S_HEXH.
// Throughput: one word per cycle while i_out_ready is high, save in S_IDLE and short-chunk S_HEXH.
// A data word that does not complete a chunk keeps S_IDLE, so words may arrive back to back.
// A chunk keeps the input off from S_HEXH through S_LF2; the terminator adds S_T0 through S_TLF2.
// Reset is synchronous and active low: buffer empty, chunk size 10, output register empty.
module chunked_transfer_framer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ctf_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  ctf_pkg::t_in_word           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output ctf_pkg::t_out_word          o_out_data
);
    import ctf_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    ctf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in_data.mode),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ctf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import ctf_pkg::*;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_END = 1'b1;
    localparam logic [CFG_W-1:0] SIZE_AFTER_RESET = 6'd10;
    localparam int MAX_GAP = 8;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD = 300;
    localparam int PRINT_LIMIT = 40;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in_word in_word = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out_word out_word;

    logic [7:0] body_bytes [CHUNK_MAX];
    int unsigned held_count = 0;
    logic [CFG_W-1:0] chunk_size_reg = SIZE_AFTER_RESET;
    t_out_word framed_q[$];
    int errors = 0;
    bit no_idle = 1'b0;
    int hold_left = 0;
    int rx_wait = 0;

    chunked_transfer_framer_core uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data(cfg_data),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_data(in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data(out_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report(input string what, input int got, input int want);
        errors++;
        if (errors <= PRINT_LIMIT) begin
            $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib > 4'd9) ? (CHAR_A + nib - 8'd10) : (CHAR_ZERO + nib);
    endfunction

    function automatic int unsigned chunk_limit();
        int unsigned s;
        s = chunk_size_reg;
        if (s < 1) begin
            s = 1;
        end
        if (s > CHUNK_MAX) begin
            s = CHUNK_MAX;
        end
        return s;
    endfunction

    function automatic void expect_byte(input logic [7:0] b);
        t_out_word w;
        w.out_byte = b;
        w.last_of_run = 1'b0;
        w.message_done = 1'b0;
        framed_q.push_back(w);
    endfunction

    function automatic void expect_chunk();
        int n;
        n = held_count;
        if (n >= 16) begin
            expect_byte(hex_char(n[7:4]));
        end
        expect_byte(hex_char(n[3:0]));
        expect_byte(CHAR_CR);
        expect_byte(CHAR_LF);
        for (int i = 0; i < n; i++) begin
            expect_byte(body_bytes[i]);
        end
        expect_byte(CHAR_CR);
        expect_byte(CHAR_LF);
        held_count = 0;
    endfunction

    function automatic void predict_word(input t_in_word w);
        int unsigned start_size;
        t_out_word tail;
        start_size = framed_q.size();
        if (w.mode == MODE_BYTE) begin
            if (held_count < CHUNK_MAX) begin
                body_bytes[held_count] = w.data_byte;
                held_count++;
            end
            if (held_count >= chunk_limit()) begin
                expect_chunk();
            end
        end else begin
            if (held_count > 0) begin
                expect_chunk();
            end
            expect_byte(CHAR_ZERO);
            expect_byte(CHAR_CR);
            expect_byte(CHAR_LF);
            expect_byte(CHAR_CR);
            expect_byte(CHAR_LF);
            tail = framed_q.pop_back();
            tail.message_done = 1'b1;
            framed_q.push_back(tail);
        end
        if (framed_q.size() > start_size) begin
            tail = framed_q.pop_back();
            tail.last_of_run = 1'b1;
            framed_q.push_back(tail);
        end
    endfunction

    task automatic check_word(input t_out_word got);
        t_out_word want;
        if (framed_q.size() == 0) begin
            report("unexpected word", got.out_byte, 0);
        end else begin
            want = framed_q.pop_front();
            if (got.out_byte !== want.out_byte) begin
                report("out_byte", got.out_byte, want.out_byte);
            end
            if (got.last_of_run !== want.last_of_run) begin
                report("last_of_run", got.last_of_run, want.last_of_run);
            end
            if (got.message_done !== want.message_done) begin
                report("message_done", got.message_done, want.message_done);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_ready && out_valid === 1'b1) begin
            check_word(out_word);
            rx_wait = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_word(input logic mode, input logic [7:0] data);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word <= {mode, data};
        do @(posedge i_clk); while (in_ready !== 1'b1);
        predict_word(in_word);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (framed_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_chunk_size(input logic [CFG_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge i_clk); while (cfg_ready !== 1'b1);
        chunk_size_reg = value;
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_default_chunk();
        send_word(MODE_BYTE, 8'h00);
        send_word(MODE_BYTE, 8'hFF);
        for (int i = 0; i < 8; i++) begin
            send_word(MODE_BYTE, 8'h01 << i);
        end
    endtask

    task automatic test_end_of_body();
        send_word(MODE_END, 8'hA5);
        send_word(MODE_BYTE, 8'h00);
        send_word(MODE_BYTE, 8'h7F);
        send_word(MODE_BYTE, 8'h80);
        send_word(MODE_END, 8'h00);
    endtask

    task automatic test_size_limits();
        write_chunk_size(6'd0);
        send_word(MODE_BYTE, 8'h5A);
        write_chunk_size(6'd1);
        send_word(MODE_BYTE, 8'hC3);
        write_chunk_size(6'd10);
        for (int i = 0; i < 4; i++) begin
            send_word(MODE_BYTE, 8'($urandom_range(0, 255)));
        end
        // Lowering the size below the fill level sends the whole buffer on the next word.
        write_chunk_size(6'd2);
        send_word(MODE_BYTE, 8'h33);
        send_word(MODE_END, 8'hFF);
    endtask

    task automatic test_backpressure();
        write_chunk_size(6'd4);
        hold_left = LONG_HOLD;
        no_idle = 1'b1;
        for (int i = 0; i < 40; i++) begin
            send_word(MODE_BYTE, 8'($urandom_range(0, 255)));
        end
        send_word(MODE_END, 8'($urandom_range(0, 255)));
        no_idle = 1'b0;
        drain();
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] size_pick;
        for (int phase = 0; phase < 12; phase++) begin
            case (phase % 6)
                0: size_pick = 6'd1;
                1: size_pick = 6'd32;
                2: size_pick = 6'd0;
                3: size_pick = (phase == 3) ? 6'd63 : 6'($urandom_range(33, 63));
                default: size_pick = 6'($urandom_range(2, 31));
            endcase
            write_chunk_size(size_pick);
            no_idle = (phase % 4 == 1);
            for (int i = 0; i < 35; i++) begin
                if ($urandom_range(0, 99) < 6) begin
                    send_word(MODE_END, 8'($urandom_range(0, 255)));
                end else begin
                    send_word(MODE_BYTE, 8'($urandom_range(0, 255)));
                end
            end
            no_idle = 1'b0;
        end
        send_word(MODE_END, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_chunk();
        test_end_of_body();
        test_size_limits();
        test_backpressure();
        test_random_traffic();
        drain();
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ctf_pkg.sv
hdl/ctf_ctrl.sv
hdl/ctf_datapath.sv
hdl/chunked_transfer_framer_core.sv
tb/testbench.sv
